// ===== design/isotp_rr_pkg.sv =====
// shared constants and types of the iso-tp receive reassembler
package isotp_rr_pkg;

   // message store geometry: one row holds one 8-byte chunk
   localparam int BUFFER_BYTES = 256;
   localparam int LANES        = 8;
   localparam int ROW_COUNT    = BUFFER_BYTES / LANES;
   localparam int ROW_W        = $clog2(ROW_COUNT);
   localparam int POS_W        = $clog2(BUFFER_BYTES + 1);

   // stream widths
   localparam int REQ_TDATA_W  = 72;
   localparam int RSP_TDATA_W  = 88;

   // frame layout
   localparam logic [3:0] MAX_DLC      = 4'd8;
   localparam logic [3:0] PCI_SINGLE   = 4'd0;
   localparam logic [3:0] PCI_FIRST    = 4'd1;
   localparam logic [3:0] PCI_CONSEC   = 4'd2;

   // service codes that carry a module id
   localparam logic [7:0] SVC_READ_DID = 8'h62;
   localparam logic [7:0] SVC_ROUTINE  = 8'h71;
   localparam logic [7:0] SVC_DTC      = 8'h59;
   localparam logic [7:0] MODULE_DTC   = 8'h02;

   // fixed flow control frame 07 30 03 00 ..
   localparam logic [7:0]  FC_BYTE0    = 8'h07;
   localparam logic [7:0]  FC_BYTE1    = 8'h30;
   localparam logic [7:0]  FC_BYTE2    = 8'h03;
   localparam logic [11:0] FC_LENGTH   = 12'd8;

   // flow control every third consecutive frame
   localparam logic [1:0] BATCH_LAST   = 2'd2;

   localparam logic [7:0] TIMEOUT_RESET = 8'd20;

   // result kind carried on tuser
   typedef enum logic [1:0] {
      KIND_FLOW_CTRL = 2'd0,
      KIND_SINGLE    = 2'd1,
      KIND_CHUNK     = 2'd2
   } kind_type;

endpackage

// ===== design/isotp_receive_reassembler_core.sv =====
// iso-tp receive reassembler with extended addressing, row-organised message store
//
//  channel | dir | handshake              | content
//  req     | in  | req_tvalid/req_tready  | tuser action, tdata frame length and bytes 0..7
//  rsp     | out | rsp_tvalid/rsp_tready  | tuser kind, tlast last result, tdata module/len/bytes
//  csr     | in  | csr_wr_en              | csr_wr_data timeout_ticks
//
// a beat is decoded in the cycle after acceptance; ticks and ignored frames then return to idle,
// single frames pass through a response state and first frames through row writes and flow control.
// payload goes to a 32 x 64-bit store with byte enables in one or two row writes.
// a completed message is read back one row per chunk, each row read and then presented,
// and the next beat is taken when delivery is done.
// synchronous reset clears control state only; the store is not cleared.
// a stalled rsp holds its beat and the sequencer waits on it.
module isotp_receive_reassembler_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // frame_length [3:0], byte0 [11:4] .. byte7 [67:60], zero fill
   input  logic [isotp_rr_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // module_id [7:0], msg_length [19:8], out0 [27:20] .. out7 [83:76], zero fill
   output logic [isotp_rr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // kind
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_wr_en,
   input  logic [7:0]                           csr_wr_data
);

   localparam int POS_W = isotp_rr_pkg::POS_W;
   localparam int ROW_W = isotp_rr_pkg::ROW_W;
   localparam int LANES = isotp_rr_pkg::LANES;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_WR_LO, S_WR_HI, S_SF, S_FC, S_RD, S_CHUNK
   } state_type;

   state_type   state_ff;

   // latched beat
   logic        tick_ff;
   logic [3:0]  dlc_ff;
   logic [7:0]  d_ff [8];

   // transfer state
   logic        rx_ff;
   logic [11:0] expected_ff;
   logic [POS_W-1:0] stored_ff;
   logic [7:0]  module_ff;
   logic [1:0]  batch_ff;
   logic [7:0]  idle_ff;
   logic [7:0]  timeout_ff;

   // write and delivery sequencing
   logic [POS_W-1:0] wr_pos_ff;
   logic [2:0]  wr_cnt_ff;
   logic [7:0]  pl_ff [6];
   logic        fc_pend_ff;
   logic        chunk_pend_ff;
   logic [POS_W-1:0] len_ff;
   logic [POS_W-1:0] ch_pos_ff;

   // output register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [7:0]  rsp_module_ff;
   logic [11:0] rsp_len_ff;
   logic [7:0]  rsp_bytes_ff [8];
   logic        rsp_last_ff;

   // message store
   logic [7:0]  store_ram [isotp_rr_pkg::ROW_COUNT][LANES];
   logic [7:0]  rd_row_ff [LANES];

   // unpacked request
   logic [7:0]  req_byte [8];
   logic [3:0]  req_dlc;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         req_byte[k] = req_tdata[4 + 8 * k +: 8];
      end
      req_dlc = (req_tdata[3:0] > isotp_rr_pkg::MAX_DLC) ? isotp_rr_pkg::MAX_DLC
                                                          : req_tdata[3:0];
   end

   // decode of the latched beat
   logic [3:0]  pci;
   logic [2:0]  cf_n;
   logic [2:0]  ff_n;
   logic [11:0] ff_expected;
   logic        ff_done;
   logic [7:0]  ff_service;
   logic [7:0]  ff_module;
   logic [POS_W:0] cf_sum;
   logic        cf_write;
   logic        cf_over;
   logic        cf_done;
   logic [7:0]  sf_bytes [8];
   logic [7:0]  sf_module;

   always_comb begin
      pci         = d_ff[1][7:4];
      cf_n        = 3'(dlc_ff - 4'd2);
      ff_n        = (dlc_ff > 4'd3) ? 3'(dlc_ff - 4'd3) : 3'd0;
      ff_expected = {d_ff[1][3:0], d_ff[2]};
      ff_done     = (ff_n != 3'd0) && (12'(ff_n) >= ff_expected);
      ff_service  = (dlc_ff > 4'd3) ? d_ff[3] : 8'd0;
      if (ff_service == isotp_rr_pkg::SVC_DTC) begin
         ff_module = (dlc_ff > 4'd4) ? d_ff[4] : 8'd0;
      end else begin
         ff_module = (dlc_ff > 4'd5) ? d_ff[5] : 8'd0;
      end
      cf_sum   = {1'b0, stored_ff} + (POS_W + 1)'(cf_n);
      cf_over  = (cf_n != 3'd0) && (cf_sum > (POS_W + 1)'(isotp_rr_pkg::BUFFER_BYTES));
      cf_write = (cf_n != 3'd0) && !cf_over;
      cf_done  = cf_write && (12'(cf_sum) >= expected_ff);
      // single frame payload and module id
      for (int i = 0; i < 8; i++) begin
         sf_bytes[i] = (i < 6 && 3'(i) < cf_n) ? d_ff[3'(i + 2)] : 8'd0;
      end
      if (cf_n >= 3'd3 && sf_bytes[0] == isotp_rr_pkg::SVC_READ_DID) begin
         sf_module = sf_bytes[2];
      end else if (cf_n >= 3'd4 && sf_bytes[0] == isotp_rr_pkg::SVC_ROUTINE) begin
         sf_module = sf_bytes[3];
      end else if (cf_n >= 3'd1 && sf_bytes[0] == isotp_rr_pkg::SVC_DTC) begin
         sf_module = isotp_rr_pkg::MODULE_DTC;
      end else begin
         sf_module = 8'd0;
      end
   end

   // payload placed in a two-row window at the write offset
   logic [7:0]  win_byte [16];
   logic [15:0] win_en;
   logic        wr_hi_needed;
   logic [ROW_W-1:0] wr_row;

   always_comb begin
      for (int l = 0; l < 16; l++) begin
         win_byte[l] = 8'd0;
      end
      win_en = '0;
      for (int i = 0; i < 6; i++) begin
         if (3'(i) < wr_cnt_ff) begin
            win_byte[4'(i) + {1'b0, wr_pos_ff[2:0]}] = pl_ff[i];
            win_en[4'(i) + {1'b0, wr_pos_ff[2:0]}]   = 1'b1;
         end
      end
      wr_hi_needed = |win_en[15:8];
      wr_row       = wr_pos_ff[ROW_W+2:3];
   end

   // chunk lane mask and end of message
   logic [POS_W:0] ch_next;
   logic        ch_last;
   logic [7:0]  ch_bytes [LANES];

   always_comb begin
      ch_next = {1'b0, ch_pos_ff} + (POS_W + 1)'(LANES);
      ch_last = ch_next >= {1'b0, len_ff};
      for (int l = 0; l < LANES; l++) begin
         ch_bytes[l] = (({1'b0, ch_pos_ff} + (POS_W + 1)'(l)) < {1'b0, len_ff})
                       ? rd_row_ff[l] : 8'd0;
      end
   end

   logic rsp_free;
   logic rsp_load;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = rsp_free && (state_ff == S_SF || state_ff == S_FC ||
                                    state_ff == S_CHUNK);
   assign req_tready = (state_ff == S_IDLE) && !reset;

   // store row write with byte enables, registered row read
   always_ff @(posedge clock) begin
      if (state_ff == S_WR_LO) begin
         for (int l = 0; l < LANES; l++) begin
            if (win_en[l]) begin
               store_ram[wr_row][l] <= win_byte[l];
            end
         end
      end else if (state_ff == S_WR_HI) begin
         for (int l = 0; l < LANES; l++) begin
            if (win_en[l + LANES]) begin
               store_ram[ROW_W'(wr_row + 1'b1)][l] <= win_byte[l + LANES];
            end
         end
      end
      if (state_ff == S_RD) begin
         rd_row_ff <= store_ram[ch_pos_ff[ROW_W+2:3]];
      end
   end

   // sequencer, transfer state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rx_ff         <= 1'b0;
         expected_ff   <= 12'd0;
         stored_ff     <= '0;
         module_ff     <= 8'd0;
         batch_ff      <= 2'd0;
         idle_ff       <= 8'd0;
         timeout_ff    <= isotp_rr_pkg::TIMEOUT_RESET;
         fc_pend_ff    <= 1'b0;
         chunk_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         // output valid: a new beat takes over from the one leaving
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  tick_ff  <= req_tuser;
                  dlc_ff   <= req_dlc;
                  d_ff     <= req_byte;
                  state_ff <= S_DECODE;
               end
            end

            S_DECODE: begin
               if (tick_ff) begin
                  // tick: count quiet time, abort a stalled transfer
                  if (rx_ff) begin
                     if (idle_ff >= timeout_ff) begin
                        rx_ff     <= 1'b0;
                        stored_ff <= '0;
                        idle_ff   <= 8'd0;
                     end else begin
                        idle_ff <= idle_ff + 8'd1;
                     end
                  end
                  state_ff <= S_IDLE;
               end else if (dlc_ff >= 4'd2) begin
                  if (pci == isotp_rr_pkg::PCI_SINGLE) begin
                     state_ff <= S_SF;
                  end else if (pci == isotp_rr_pkg::PCI_FIRST) begin
                     // first frame restarts reassembly
                     rx_ff         <= !ff_done;
                     expected_ff   <= ff_expected;
                     stored_ff     <= ff_done ? '0 : POS_W'(ff_n);
                     module_ff     <= ff_module;
                     batch_ff      <= 2'd0;
                     idle_ff       <= 8'd0;
                     wr_pos_ff     <= '0;
                     wr_cnt_ff     <= ff_n;
                     pl_ff         <= '{d_ff[3], d_ff[4], d_ff[5], d_ff[6], d_ff[7], 8'd0};
                     fc_pend_ff    <= 1'b1;
                     chunk_pend_ff <= 1'b0;
                     state_ff      <= (ff_n != 3'd0) ? S_WR_LO : S_FC;
                  end else if (pci == isotp_rr_pkg::PCI_CONSEC && rx_ff) begin
                     // consecutive frame: append, count the block, maybe complete
                     wr_pos_ff <= stored_ff;
                     wr_cnt_ff <= cf_n;
                     pl_ff     <= '{d_ff[2], d_ff[3], d_ff[4], d_ff[5], d_ff[6], d_ff[7]};
                     len_ff    <= POS_W'(cf_sum);
                     if (cf_over) begin
                        rx_ff     <= 1'b0;
                        stored_ff <= '0;
                        idle_ff   <= 8'd0;
                     end else if (cf_write) begin
                        idle_ff   <= 8'd0;
                        rx_ff     <= !cf_done;
                        stored_ff <= cf_done ? '0 : POS_W'(cf_sum);
                     end
                     batch_ff      <= (batch_ff == isotp_rr_pkg::BATCH_LAST) ? 2'd0
                                                                             : batch_ff + 2'd1;
                     fc_pend_ff    <= (batch_ff == isotp_rr_pkg::BATCH_LAST);
                     chunk_pend_ff <= cf_done;
                     if (cf_write) begin
                        state_ff <= S_WR_LO;
                     end else if (batch_ff == isotp_rr_pkg::BATCH_LAST) begin
                        state_ff <= S_FC;
                     end else begin
                        state_ff <= S_IDLE;
                     end
                  end else begin
                     // other pci types and stray consecutive frames
                     state_ff <= S_IDLE;
                  end
               end else begin
                  // short frame
                  state_ff <= S_IDLE;
               end
            end

            S_WR_LO, S_WR_HI: begin
               ch_pos_ff <= '0;
               if (state_ff == S_WR_LO && wr_hi_needed) begin
                  state_ff <= S_WR_HI;
               end else if (fc_pend_ff) begin
                  state_ff <= S_FC;
               end else if (chunk_pend_ff) begin
                  state_ff <= S_RD;
               end else begin
                  state_ff <= S_IDLE;
               end
            end

            S_SF: begin
               if (rsp_free) begin
                  rsp_kind_ff   <= isotp_rr_pkg::KIND_SINGLE;
                  rsp_module_ff <= sf_module;
                  rsp_len_ff    <= 12'(cf_n);
                  rsp_bytes_ff  <= sf_bytes;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end

            S_FC: begin
               if (rsp_free) begin
                  rsp_kind_ff   <= isotp_rr_pkg::KIND_FLOW_CTRL;
                  rsp_module_ff <= 8'd0;
                  rsp_len_ff    <= isotp_rr_pkg::FC_LENGTH;
                  rsp_bytes_ff  <= '{isotp_rr_pkg::FC_BYTE0, isotp_rr_pkg::FC_BYTE1,
                                     isotp_rr_pkg::FC_BYTE2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
                  rsp_last_ff   <= !chunk_pend_ff;
                  ch_pos_ff     <= '0;
                  state_ff      <= chunk_pend_ff ? S_RD : S_IDLE;
               end
            end

            S_RD: begin
               state_ff <= S_CHUNK;
            end

            S_CHUNK: begin
               if (rsp_free) begin
                  rsp_kind_ff   <= isotp_rr_pkg::KIND_CHUNK;
                  rsp_module_ff <= module_ff;
                  rsp_len_ff    <= 12'(len_ff);
                  rsp_bytes_ff  <= ch_bytes;
                  rsp_last_ff   <= ch_last;
                  ch_pos_ff     <= POS_W'(ch_next);
                  state_ff      <= ch_last ? S_IDLE : S_RD;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'd0,
                        rsp_bytes_ff[7], rsp_bytes_ff[6], rsp_bytes_ff[5], rsp_bytes_ff[4],
                        rsp_bytes_ff[3], rsp_bytes_ff[2], rsp_bytes_ff[1], rsp_bytes_ff[0],
                        rsp_len_ff, rsp_module_ff};

`ifndef NO_ASSERTIONS
   // an idle receiver holds no partial message
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !rx_ff |-> stored_ff == '0)
      else $error("stored bytes left while not receiving");

   // fill level never passes the store size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, stored_ff} <= (POS_W + 1)'(isotp_rr_pkg::BUFFER_BYTES))
      else $error("store fill beyond capacity");

   // block counter wraps after the third frame
   a_batch_range: assert property (@(posedge clock) disable iff (reset)
      batch_ff != 2'd3)
      else $error("block counter out of range");

   // chunk data is only presented after a row read
   a_chunk_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHUNK |-> $past(state_ff) == S_RD || $past(state_ff) == S_CHUNK)
      else $error("chunk presented without row read");

   // no beat accepted while a message is being delivered
   a_no_accept_in_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD |=> !req_tready)
      else $error("input taken during chunk delivery");
`endif

endmodule
